// File: sv/ntsd_pkg.sv
// ----------------------------------------------------------------------------
// ntsd_pkg
// Shared types, constants and the segment font for the seven-segment
// number formatter.
// ----------------------------------------------------------------------------
package ntsd_pkg;

    // Display geometry
    localparam int MAX_DIGITS  = 8;
    localparam int BCD_DIGITS  = 10;
    localparam int NUM_W       = 32;
    localparam int CONV_STEPS  = NUM_W;
    localparam int STEP_CNT_W  = $clog2(CONV_STEPS);

    // Register indexes on the configuration port
    localparam logic CFG_DIGIT_COUNT   = 1'b0;
    localparam logic CFG_LEADING_ZEROS = 1'b1;

    // Reset values of the registers
    localparam logic [3:0] DIGIT_COUNT_RST   = 4'd8;
    localparam logic       LEADING_ZEROS_RST = 1'b0;

    // Fixed patterns
    localparam logic [7:0] PAT_BLANK = 8'h00;
    localparam logic [7:0] PAT_MINUS = 8'h40;
    localparam logic [7:0] PAT_ZERO  = 8'h3F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FMT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic shift;     // one double-dabble step
        logic fmt_load;  // render digits into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a new result
    } sts_t;

    // gfedcba font for 0..F
    function automatic logic [7:0] hex_glyph(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'h0: p = 8'h3F;
            4'h1: p = 8'h06;
            4'h2: p = 8'h5B;
            4'h3: p = 8'h4F;
            4'h4: p = 8'h66;
            4'h5: p = 8'h6D;
            4'h6: p = 8'h7D;
            4'h7: p = 8'h07;
            4'h8: p = 8'h7F;
            4'h9: p = 8'h6F;
            4'hA: p = 8'h77;
            4'hB: p = 8'h7C;
            4'hC: p = 8'h39;
            4'hD: p = 8'h5E;
            4'hE: p = 8'h79;
            default: p = 8'h71;
        endcase
        return p;
    endfunction

endpackage

// File: sv/ntsd_ctrl.sv
// ----------------------------------------------------------------------------
// ntsd_ctrl
// Sequencer: accepts an item, runs the 32 conversion steps for decimal
// items, then hands the formatted result to the output register.
// ----------------------------------------------------------------------------
module ntsd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_hex,
    output logic          in_ready,
    output ntsd_pkg::cmd_t cmd,
    input  ntsd_pkg::sts_t sts
);
    import ntsd_pkg::*;

    state_t                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    // hex digits are the raw nibbles: no conversion
                    state_next = in_hex ? ST_FMT : ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(CONV_STEPS - 1))
                    state_next = ST_FMT;
            end
            ST_FMT:
            begin
                if (sts.out_free)
                begin
                    cmd.fmt_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // a result is never written over one that is still waiting
    a_fmt_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fmt_load |-> sts.out_free)
        else $error("result loaded while output register busy");

    // the last conversion step leads into formatting
    a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && cnt_reg == STEP_CNT_W'(CONV_STEPS - 1))
        |=> state_reg == ST_FMT)
        else $error("conversion did not end after all steps");

    // an accepted item always goes on to work
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_CONV || state_reg == ST_FMT))
        else $error("item accepted but sequencer idle");
`endif

endmodule

// File: sv/ntsd_dp.sv
// ----------------------------------------------------------------------------
// ntsd_dp
// Datapath: sign handling, shift-and-add-3 binary to BCD converter, digit
// placement and the output register.
// ----------------------------------------------------------------------------
module ntsd_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  ntsd_pkg::cmd_t      cmd,
    output ntsd_pkg::sts_t      sts,
    input  logic                in_hex,
    input  logic [31:0]         in_number,
    input  logic [3:0]          digit_count,
    input  logic                leading_zeros,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         out_data
);
    import ntsd_pkg::*;

    logic [NUM_W-1:0]        mag_reg;
    logic [BCD_DIGITS*4-1:0] bcd_reg;
    logic                    neg_reg;
    logic [BCD_DIGITS*4-1:0] bcd_adj;
    logic [BCD_DIGITS*4-1:0] bcd_next;
    logic [NUM_W-1:0]        mag_next;
    logic                    in_neg;
    logic [63:0]             out_data_reg;
    logic [63:0]             out_data_next;
    logic                    out_valid_reg;
    logic [3:0]              n_used;
    logic [3:0]              nd;
    logic [3:0]              sd;
    logic [3:0]              r;
    logic [3:0]              d;

    assign in_neg = ~in_hex & in_number[NUM_W-1];

    // add-3 correction on every BCD digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    // load or one shift step
    always_comb
    begin
        bcd_next = bcd_reg;
        mag_next = mag_reg;
        if (cmd.load)
        begin
            if (in_hex)
            begin
                bcd_next = {{(BCD_DIGITS*4-NUM_W){1'b0}}, in_number};
                mag_next = '0;
            end
            else
            begin
                bcd_next = '0;
                mag_next = in_neg ? (NUM_W'(0) - in_number) : in_number;
            end
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BCD_DIGITS*4-2:0], mag_reg[NUM_W-1]};
            mag_next = {mag_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        mag_reg <= mag_next;
        if (cmd.load)
            neg_reg <= in_neg;
    end

    // digits in use, clamped to 1..MAX_DIGITS
    always_comb
    begin
        if (digit_count == 4'd0)
            n_used = 4'd1;
        else if (digit_count > 4'(MAX_DIGITS))
            n_used = 4'(MAX_DIGITS);
        else
            n_used = digit_count;
    end

    // significant digit count (at least one) and how many fit
    always_comb
    begin
        nd = 4'd1;
        for (int i = 1; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                nd = 4'(i + 1);
        end
        sd = (nd > n_used) ? n_used : nd;
    end

    // place digits right-aligned, then sign and fill
    always_comb
    begin
        out_data_next = '0;
        r = '0;
        d = '0;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (4'(k) < n_used)
            begin
                r = n_used - 4'd1 - 4'(k);
                d = bcd_reg[r*4 +: 4];
                if (r < sd)
                    out_data_next[k*8 +: 8] = hex_glyph(d);
                else if (leading_zeros)
                    out_data_next[k*8 +: 8] = (neg_reg && k == 0) ? PAT_MINUS : PAT_ZERO;
                else if (neg_reg && r == sd)
                    out_data_next[k*8 +: 8] = PAT_MINUS;
                else
                    out_data_next[k*8 +: 8] = PAT_BLANK;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.fmt_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fmt_load)
            out_data_reg <= out_data_next;
    end

    assign sts.out_free = ~out_valid_reg | out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

// File: sv/number_to_seven_segment_digits.sv
// ----------------------------------------------------------------------------
// number_to_seven_segment_digits
// Renders a 32-bit value as signed decimal or unsigned hex into up to eight
// right-aligned seven-segment patterns.
// ----------------------------------------------------------------------------
// A decimal item occupies the block for the accepting cycle, 32 steps of the
// shift-and-add-3 converter (one input bit per cycle) and a formatting step
// that places the digits into the output register once that register is free.
// A hex item skips the converter and goes from acceptance straight to the
// formatting step. One item is in work at a time; the next is accepted as soon
// as the result has moved to the output register, even if that result is not
// yet taken. Write configuration only while idle.
module number_to_seven_segment_digits (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] number
    input  logic        s_tuser,   // [0] req_type: 0 decimal, 1 hex
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digit_0 [7:0] .. digit_7 [63:56]
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);
    import ntsd_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic [3:0] digit_count_reg;
    logic       leading_zeros_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg   <= DIGIT_COUNT_RST;
            leading_zeros_reg <= LEADING_ZEROS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIGIT_COUNT:   digit_count_reg   <= cfg_data;
                CFG_LEADING_ZEROS: leading_zeros_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    ntsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_hex   (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ntsd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_hex        (s_tuser),
        .in_number     (s_tdata),
        .digit_count   (digit_count_reg),
        .leading_zeros (leading_zeros_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (m_tdata)
    );

endmodule

// File: tb/number_to_seven_segment_digits_test.sv
// ----------------------------------------------------------------------------
// number_to_seven_segment_digits_test
// Self-checking bench for the seven-segment number formatter. Random signed
// decimal and hex items are streamed in across a sweep of digit counts and
// leading-zero settings. Each output item is checked digit by digit against
// patterns predicted inside the bench. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module number_to_seven_segment_digits_test;
    import ntsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;

    // Fixed register sweep, extremes and out-of-range counts included
    localparam logic [3:0] SWEEP_COUNTS [8] = '{4'd1, 4'd1, 4'd0, 4'd0, 4'd15, 4'd9, 4'd8, 4'd8};
    localparam bit         SWEEP_LZ     [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    // ------------------------------------------------------------------------
    // Expected-digit store and predictor
    // ------------------------------------------------------------------------
    class digit_scoreboard;
        logic [3:0]  digit_count;
        bit          leading_zeros;
        logic [63:0] expected_digits[$];
        int          errors;

        function new();
            digit_count   = DIGIT_COUNT_RST;
            leading_zeros = LEADING_ZEROS_RST;
            errors        = 0;
        endfunction

        function void set_register(logic idx, logic [3:0] data);
            if (idx == CFG_DIGIT_COUNT)
                digit_count = data;
            else if (idx == CFG_LEADING_ZEROS)
                leading_zeros = data[0];
        endfunction

        // gfedcba glyph of one hex digit
        function logic [7:0] glyph(logic [31:0] d);
            case (d[3:0])
                4'h0: return 8'h3F;
                4'h1: return 8'h06;
                4'h2: return 8'h5B;
                4'h3: return 8'h4F;
                4'h4: return 8'h66;
                4'h5: return 8'h6D;
                4'h6: return 8'h7D;
                4'h7: return 8'h07;
                4'h8: return 8'h7F;
                4'h9: return 8'h6F;
                4'hA: return 8'h77;
                4'hB: return 8'h7C;
                4'hC: return 8'h39;
                4'hD: return 8'h5E;
                4'hE: return 8'h79;
                default: return 8'h71;
            endcase
        endfunction

        function logic [63:0] render_digits(bit hex, logic [31:0] value);
            logic [7:0]  cells [8];
            logic [31:0] mag;
            logic [31:0] base;
            logic [63:0] word;
            bit          negative;
            int          used;
            int          pos;
            used = digit_count;
            if (used < 1)
                used = 1;
            if (used > MAX_DIGITS)
                used = MAX_DIGITS;
            foreach (cells[i])
                cells[i] = PAT_BLANK;
            negative = !hex && value[31];
            mag      = negative ? (32'd0 - value) : value;
            base     = hex ? 32'd16 : 32'd10;
            // right to left; zero still yields one '0'
            pos = used - 1;
            do
            begin
                cells[pos] = glyph(mag % base);
                mag        = mag / base;
                pos--;
            end while (mag != 0 && pos >= 0);
            // fill what is left of the digits
            if (pos >= 0)
            begin
                if (leading_zeros)
                begin
                    for (int i = 0; i <= pos; i++)
                        cells[i] = PAT_ZERO;
                    if (negative)
                        cells[0] = PAT_MINUS;
                end
                else if (negative)
                    cells[pos] = PAT_MINUS;
            end
            word = '0;
            for (int i = 0; i < used; i++)
                word[8*i +: 8] = cells[i];
            return word;
        endfunction

        function void note_number(bit hex, logic [31:0] value);
            expected_digits.push_back(render_digits(hex, value));
        endfunction

        function void check_digits(logic [63:0] got);
            logic [63:0] want;
            if (expected_digits.size() == 0)
            begin
                $error("result with no item pending: %h", got);
                errors++;
                return;
            end
            want = expected_digits.pop_front();
            for (int k = 0; k < 8; k++)
            begin
                if (got[8*k +: 8] !== want[8*k +: 8])
                begin
                    $error("digit_%0d: expected %02h, got %02h", k, want[8*k +: 8],
                           got[8*k +: 8]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] number
    logic        s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // digit_0 [7:0] .. digit_7 [63:56]
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    digit_scoreboard sb = new();

    bit rx_throttle;
    bit rx_long_hold;
    bit tx_steady;
    int quiet_cycles;

    number_to_seven_segment_digits dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Monitor: check results, record accepted items, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_digits(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_number(s_tuser, s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no item accepted for %0d cycles", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Full-range, small and extreme values, and values sized to land near the digit-count boundaries
    function automatic logic [31:0] pick_number(bit hex);
        int          sel;
        int          k;
        logic [63:0] lim;
        logic [63:0] mask;
        logic [31:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom;
        if (sel < 5)
            v = $urandom_range(0, 20);
        else if (sel < 9)
        begin
            if (hex)
            begin
                k    = $urandom_range(1, 8);
                mask = (64'd1 << (4 * k)) - 64'd1;
                v    = 32'($urandom) & mask[31:0];
            end
            else
            begin
                k   = $urandom_range(1, 10);
                lim = 64'd1;
                repeat (k) lim = lim * 64'd10;
                v = 32'(64'($urandom) % lim);
            end
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: v = 32'h0000_0000;
                1: v = 32'h8000_0000;
                2: v = 32'hFFFF_FFFF;
                3: v = 32'h7FFF_FFFF;
                4: v = 32'd99999999;
                default: v = 32'd100000000;
            endcase
        end
        if (!hex && $urandom_range(0, 1) == 1)
            v = 32'd0 - v;
        return v;
    endfunction

    // Offer one item and hold it until taken
    task automatic send_item(bit hex, logic [31:0] value, int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= hex;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic idx, logic [3:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, data);
    endtask

    // Wait until every pending result has been taken
    task automatic wait_idle();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One register setting followed by a burst of random items
    task automatic run_phase(logic [3:0] count_val, bit lz, int n_items, bit squeeze);
        bit hex;
        int gap;
        wait_idle();
        write_reg(CFG_DIGIT_COUNT, count_val);
        write_reg(CFG_LEADING_ZEROS, {3'($urandom), lz});
        tx_steady   = ($urandom_range(0, 3) == 0);
        rx_throttle = ($urandom_range(0, 3) != 0);
        // receiver holds off while the sender keeps offering
        if (squeeze)
        begin
            rx_throttle  = 1'b0;
            rx_long_hold = 1'b1;
        end
        for (int i = 0; i < n_items; i++)
        begin
            hex = $urandom_range(0, 1);
            gap = (tx_steady || (squeeze && i < 16)) ? 0 : pick_gap();
            send_item(hex, pick_number(hex), gap);
        end
        s_tvalid <= 1'b0;
    endtask

    // Receiver: ready with random stalls, plus one long hold on request
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_long_hold)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_long_hold = 1'b0;
            end
            else if (rx_throttle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        logic [3:0] dc;
        int         v;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DIGIT_COUNT;
        cfg_data  <= '0;
        rx_throttle  = 1'b0;
        rx_long_hold = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings: eight digits, blanks
        send_item(1'b0, 32'd0, 0);
        send_item(1'b1, 32'd0, 0);
        send_item(1'b0, 32'd1, 0);
        send_item(1'b0, 32'hFFFF_FFFF, 0);
        send_item(1'b1, 32'hFFFF_FFFF, 0);
        send_item(1'b0, 32'h7FFF_FFFF, 0);
        send_item(1'b0, 32'h8000_0000, 0);   // most negative, truncated
        send_item(1'b0, 32'd12345678, 0);
        send_item(1'b0, -32'd1234567, 0);    // minus fills the last slot
        send_item(1'b0, -32'd12345678, 0);   // no room for the minus
        send_item(1'b0, 32'd123456789, 0);
        send_item(1'b1, 32'h1234_5678, 0);
        send_item(1'b1, 32'h89AB_CDEF, 0);
        send_item(1'b1, 32'h0000_0ABC, 0);
        send_item(1'b0, 32'd42, 0);
        s_tvalid <= 1'b0;

        // Leading zeros on, upper data bits set
        wait_idle();
        write_reg(CFG_LEADING_ZEROS, 4'b1011);
        send_item(1'b0, -32'd5, 0);          // minus moves to the left edge
        send_item(1'b0, 32'd42, 0);
        send_item(1'b1, 32'd0, 0);
        send_item(1'b0, -32'd12345678, 0);
        send_item(1'b0, 32'd0, 0);
        s_tvalid <= 1'b0;

        // Fixed sweep of register settings
        for (int p = 0; p < 8; p++)
            run_phase(SWEEP_COUNTS[p], SWEEP_LZ[p], 60, 1'b0);

        // Random settings, one phase with a long receiver stall
        for (int p = 0; p < 11; p++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                v  = $urandom_range(9, 16);
                dc = 4'(v);
            end
            else
                dc = 4'($urandom_range(1, 8));
            run_phase(dc, 1'($urandom_range(0, 1)), 120, p == 3);
        end

        // Drain and settle
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
